@@ src/cfc_pkg.sv @@
// Shared types and constants for the causal FIR convolver.
package cfc_pkg;

    localparam int SAMPLE_W = 16;   // Q4.12 sample
    localparam int TAP_W    = 16;   // Q1.15 coefficient
    localparam int PROD_W   = SAMPLE_W + TAP_W;  // Q5.27 product
    localparam int IDX_W    = 5;
    localparam int OUT_W    = 32;   // Q20.12 result
    localparam int WIDE_W   = 48;   // rounding / saturation width
    localparam int FRAC_DROP = 15;  // Q5.27 -> Q20.12

    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_LOAD   = 1'b1;

    // per-cell control, broadcast down the row
    typedef struct packed {
        logic shift;    // move delay line one cell
        logic clear;    // zero the delay line (series start)
        logic tap_we;   // write this cell's coefficient
    } cell_ctrl_t;

endpackage

@@ src/cfc_cell.sv @@
// One FIR cell: a delay-line stage, its coefficient, and a multiply-accumulate stage.
module cfc_cell
    import cfc_pkg::*;
#(
    parameter int ACC_W = 38
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  cell_ctrl_t                 ctrl,
    input  logic signed [TAP_W-1:0]    tap_value,
    input  logic signed [SAMPLE_W-1:0] sample_in,
    output logic signed [SAMPLE_W-1:0] sample_out,
    input  logic signed [ACC_W-1:0]    acc_in,
    output logic signed [ACC_W-1:0]    acc_out
);

    logic signed [SAMPLE_W-1:0] sample_reg, sample_next;
    logic signed [TAP_W-1:0]    tap_reg, tap_next;
    logic signed [ACC_W-1:0]    acc_reg, acc_next;
    logic signed [PROD_W-1:0]   product;

    always_comb begin
        sample_next = sample_reg;
        if (ctrl.shift) begin
            sample_next = sample_in;
        end else if (ctrl.clear) begin
            sample_next = '0;
        end
        tap_next = ctrl.tap_we ? tap_value : tap_reg;
        product  = sample_reg * tap_reg;
        acc_next = acc_in + ACC_W'(product);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_reg <= '0;
            tap_reg    <= '0;
        end else begin
            sample_reg <= sample_next;
            tap_reg    <= tap_next;
        end
    end

    // partial sum moves one cell per cycle
    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

    assign sample_out = sample_reg;
    assign acc_out    = acc_reg;

endmodule

@@ src/causal_fir_convolver.sv @@
// Top level of the causal FIR convolver: input decode, cell row, rounding and output register.
//
// Usage:
//   Input words arrive on s_axis_*. tuser[0] selects the kind: a load word
//   writes one coefficient (tap_index, tap_value) and gives no result; a
//   sample word shifts sample_value into the delay line and gives exactly
//   one result word on m_axis_*. tuser[1] on a sample word clears the delay
//   line first, starting a new series. Load indexes at or above NUM_TAPS
//   are dropped.
//   Result: m_axis_tdata is the Q20.12 sum, rounded to nearest (ties up)
//   and clipped to 32 bits; m_axis_tuser flags a clipped sum.
// Timing:
//   An accepted sample word's partial sum walks the row of NUM_TAPS
//   cells, one cell per cycle, then is rounded into the output register.
//   One sample word is in the row at a time and the row frees only after
//   its sum has moved to the output register, so a new sample is not
//   taken before the last one's result is registered. A load word is
//   accepted whenever the row is idle.
// Reset:
//   Delay line and coefficients clear to zero; no result is pending.
// Back-pressure:
//   The output register holds a result while m_axis_tready is low; the
//   next sample still enters the row and its finished sum waits at the
//   last cell until the output register frees up.
module causal_fir_convolver
    import cfc_pkg::*;
#(
    parameter int NUM_TAPS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [4:0] tap_index, [20:5] tap_value, [36:21] sample_value, [39:37] zero
    input  logic [39:0] s_axis_tdata,
    // [0] req_type, [1] series_start
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [31:0] conv_value
    output logic [31:0] m_axis_tdata,
    // [0] saturated
    output logic [0:0]  m_axis_tuser
);

    localparam int ACC_W = PROD_W + 1 + $clog2(NUM_TAPS);
    localparam int CNT_W = $clog2(NUM_TAPS + 1);

    // input word fields
    logic                       req_type;
    logic                       series_start;
    logic [IDX_W-1:0]           tap_index;
    logic signed [TAP_W-1:0]    tap_value;
    logic signed [SAMPLE_W-1:0] sample_value;

    assign req_type     = s_axis_tuser[0];
    assign series_start = s_axis_tuser[1];
    assign tap_index    = s_axis_tdata[4:0];
    assign tap_value    = s_axis_tdata[20:5];
    assign sample_value = s_axis_tdata[36:21];

    logic in_fire, sample_fire, load_fire;

    // sequencing: busy while a partial sum walks the row
    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             sum_done;

    // output register
    logic                    m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]        m_data_reg, m_data_next;
    logic                    m_sat_reg, m_sat_next;
    logic                    out_load;

    // cell row
    logic signed [SAMPLE_W-1:0] sample_chain [NUM_TAPS+1];
    logic signed [ACC_W-1:0]    acc_chain    [NUM_TAPS+1];
    cell_ctrl_t                 cell_ctrl    [NUM_TAPS];

    // rounding and clipping of the finished sum
    logic signed [WIDE_W-1:0] sum_wide, sum_round;
    logic [OUT_W-1:0]         conv_value;
    logic                     conv_sat;

    localparam logic signed [WIDE_W-1:0] OUT_MAX = WIDE_W'((64'sd1 <<< (OUT_W - 1)) - 1);
    localparam logic signed [WIDE_W-1:0] OUT_MIN = -WIDE_W'(64'sd1 <<< (OUT_W - 1));
    localparam logic signed [WIDE_W-1:0] HALF_LSB = WIDE_W'(64'sd1 <<< (FRAC_DROP - 1));

    assign s_axis_tready = !busy_reg;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign sample_fire   = in_fire && (req_type == REQ_SAMPLE);
    assign load_fire     = in_fire && (req_type == REQ_LOAD);

    assign sample_chain[0] = sample_value;
    assign acc_chain[0]    = '0;

    for (genvar k = 0; k < NUM_TAPS; k++) begin : g_cell
        always_comb begin
            cell_ctrl[k].shift  = sample_fire;
            cell_ctrl[k].clear  = sample_fire && series_start;
            cell_ctrl[k].tap_we = load_fire && (int'(tap_index) == k);
        end

        // first cell takes the new sample even on a series start
        cell_ctrl_t ctrl_k;
        always_comb begin
            ctrl_k = cell_ctrl[k];
            if (k != 0 && ctrl_k.clear) begin
                ctrl_k.shift = 1'b0;
            end
        end

        cfc_cell #(
            .ACC_W (ACC_W)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl_k),
            .tap_value  (tap_value),
            .sample_in  (sample_chain[k]),
            .sample_out (sample_chain[k+1]),
            .acc_in     (acc_chain[k]),
            .acc_out    (acc_chain[k+1])
        );
    end

    // round half up to Q20.12, then clip to 32 bits
    always_comb begin
        sum_wide  = WIDE_W'(acc_chain[NUM_TAPS]) + HALF_LSB;
        sum_round = sum_wide >>> FRAC_DROP;
        conv_sat  = 1'b0;
        if (sum_round > OUT_MAX) begin
            conv_value = OUT_MAX[OUT_W-1:0];
            conv_sat   = 1'b1;
        end else if (sum_round < OUT_MIN) begin
            conv_value = OUT_MIN[OUT_W-1:0];
            conv_sat   = 1'b1;
        end else begin
            conv_value = sum_round[OUT_W-1:0];
        end
    end

    // the last cell holds a valid sum once the counter loaded at the shift has run down to zero
    assign sum_done = busy_reg && (cnt_reg == '0);
    assign out_load = sum_done && (!m_valid_reg || m_axis_tready);

    always_comb begin
        busy_next    = busy_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_sat_next   = m_sat_reg;

        if (m_valid_reg && m_axis_tready) begin
            m_valid_next = 1'b0;
        end

        if (sample_fire) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_TAPS);
        end else if (busy_reg && cnt_reg != '0) begin
            cnt_next = cnt_reg - 1'b1;
        end

        if (out_load) begin
            busy_next    = 1'b0;
            m_valid_next = 1'b1;
            m_data_next  = conv_value;
            m_sat_next   = conv_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        m_sat_reg  <= m_sat_next;
    end

    assign m_axis_tvalid   = m_valid_reg;
    assign m_axis_tdata    = m_data_reg;
    assign m_axis_tuser[0] = m_sat_reg;

endmodule

@@ bench/tb_causal_fir_convolver.sv @@
`timescale 1ns / 100ps
// Self-checking bench for causal_fir_convolver: a directed table, then random kernels and series.
module tb_causal_fir_convolver;
    import cfc_pkg::*;

    localparam int NTAPS   = 32;
    localparam int N_WORDS = 550;   // input words before the stimulus stops

    // one input word, unpacked into its fields
    typedef struct packed {
        logic                       req;
        logic [IDX_W-1:0]           idx;
        logic signed [TAP_W-1:0]    coef;
        logic signed [SAMPLE_W-1:0] smp;
        logic                       start;
    } fir_word_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] value;
        logic                    sat;
    } conv_result_t;

    // directed row: a word plus, where the sum is obvious, the value to expect
    typedef struct packed {
        logic                       req;
        logic [IDX_W-1:0]           idx;
        logic signed [TAP_W-1:0]    coef;
        logic signed [SAMPLE_W-1:0] smp;
        logic                       start;
        logic                       pinned;
        logic signed [OUT_W-1:0]    want;
    } dir_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;     // [4:0] tap_index, [20:5] tap_value, [36:21] sample_value
    logic [1:0]  s_axis_tuser;     // [0] req_type, [1] series_start
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;     // [31:0] conv_value
    logic [0:0]  m_axis_tuser;     // [0] saturated

    causal_fir_convolver #(.NUM_TAPS(NTAPS)) uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // hard stop, far beyond the slowest legal run
    initial begin
        #3000000;
        $display("causal_fir_convolver test failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Filter model: own copy of the coefficients and the delay line
    // ------------------------------------------------------------------
    logic signed [SAMPLE_W-1:0] hist_model [NTAPS];
    logic signed [TAP_W-1:0]    kern_model [NTAPS];
    conv_result_t               conv_expected [$];   // sums still owed by the block

    // Applies one word; returns 1 with the sum when the word is a sample.
    function automatic bit fir_step(input fir_word_t w, output conv_result_t r);
        longint acc;
        longint rnd;
        acc = 0;
        r   = '0;
        if (w.req == REQ_LOAD) begin
            // an index past the last tap is dropped; unreachable with 32 taps
            if (w.idx < NTAPS) kern_model[w.idx] = w.coef;
            return 1'b0;
        end
        // series start: history before this sample reads as zero
        if (w.start) begin
            for (int i = 0; i < NTAPS; i++) hist_model[i] = '0;
        end
        for (int i = NTAPS - 1; i > 0; i--) hist_model[i] = hist_model[i-1];
        hist_model[0] = w.smp;
        // Q4.12 x Q1.15 products summed exactly as Q5.27
        for (int i = 0; i < NTAPS; i++)
            acc += longint'(hist_model[i]) * longint'(kern_model[i]);
        // to Q20.12: round half up, i.e. floor((acc + 2^14) / 2^15)
        rnd = (acc + 64'sd16384) >>> FRAC_DROP;
        if (rnd > 64'sd2147483647) begin
            rnd   = 64'sd2147483647;
            r.sat = 1'b1;
        end else if (rnd < -64'sd2147483648) begin
            rnd   = -64'sd2147483648;
            r.sat = 1'b1;
        end
        r.value = rnd[OUT_W-1:0];
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Directed table. Pinned rows carry a sum that is plain by inspection.
    // ------------------------------------------------------------------
    dir_row_t dir_rows [0:17] = '{
        // no taps loaded yet: every sum is zero
        '{REQ_SAMPLE, 5'd0,  16'sh0000, 16'sh1234, 1'b1, 1'b1, 32'sd0},
        // tap fields on a sample word are ignored
        '{REQ_SAMPLE, 5'd31, 16'shffff, 16'sh8000, 1'b0, 1'b1, 32'sd0},
        // load: sample field and start flag are ignored
        '{REQ_LOAD,   5'd0,  16'sh8000, 16'sh7fff, 1'b1, 1'b0, 32'sd0},
        // (-1.0 tap) x (-8.0 sample) after a clear = +8.0 = 32768 in Q20.12
        '{REQ_SAMPLE, 5'd0,  16'sh0000, 16'sh8000, 1'b1, 1'b1, 32'sd32768},
        '{REQ_SAMPLE, 5'd0,  16'sh0000, 16'sh7fff, 1'b0, 1'b0, 32'sd0},
        '{REQ_LOAD,   5'd31, 16'sh7fff, 16'sh0000, 1'b0, 1'b0, 32'sd0},
        // kernel changed mid series: applies from the next sample on
        '{REQ_LOAD,   5'd0,  16'sh7fff, 16'sh8000, 1'b0, 1'b0, 32'sd0},
        '{REQ_SAMPLE, 5'd0,  16'sh0000, 16'sh7fff, 1'b1, 1'b0, 32'sd0},
        '{REQ_SAMPLE, 5'd31, 16'sh8000, 16'shffff, 1'b0, 1'b0, 32'sd0},
        '{REQ_LOAD,   5'd1,  16'shffff, 16'sh0000, 1'b0, 1'b0, 32'sd0},
        '{REQ_SAMPLE, 5'd0,  16'sh0000, 16'sh0001, 1'b0, 1'b0, 32'sd0},
        // fresh series with a zero sample: all history gone, sum is zero
        '{REQ_SAMPLE, 5'd0,  16'sh0000, 16'sh0000, 1'b1, 1'b1, 32'sd0},
        '{REQ_LOAD,   5'd15, 16'sh5555, 16'sh0000, 1'b0, 1'b0, 32'sd0},
        '{REQ_SAMPLE, 5'd0,  16'sh0000, 16'shaaaa, 1'b0, 1'b0, 32'sd0},
        '{REQ_LOAD,   5'd16, 16'shaaaa, 16'shffff, 1'b1, 1'b0, 32'sd0},
        '{REQ_SAMPLE, 5'd0,  16'sh0000, 16'sh5555, 1'b0, 1'b0, 32'sd0},
        '{REQ_LOAD,   5'd0,  16'sh0000, 16'sh0000, 1'b0, 1'b0, 32'sd0},
        '{REQ_SAMPLE, 5'd0,  16'sh0000, 16'sh7fff, 1'b1, 1'b0, 32'sd0}
    };

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    int sent_words;
    bit src_calm;      // no gaps between words for this stretch

    task automatic send_word(input fir_word_t w, input logic pinned,
                             input logic signed [OUT_W-1:0] want);
        int           gap;
        conv_result_t r;
        gap = src_calm ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, w.smp, w.coef, w.idx};
        s_axis_tuser  <= {w.start, w.req};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        // word taken at this edge
        if (fir_step(w, r)) begin
            if (pinned) begin
                r.value = want;
                r.sat   = 1'b0;
            end
            conv_expected.push_back(r);
        end
        sent_words++;
    endtask

    // 16-bit value leaning toward the corners
    function automatic logic [15:0] pick16();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'hffff;
            3:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    int n_bad;

    initial begin
        fir_word_t   w;
        int          kind;
        int          nload;
        int          len;
        logic [15:0] ext;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        aresetn       <= 1'b0;
        sent_words    = 0;
        src_calm      = 1'b0;
        for (int i = 0; i < NTAPS; i++) begin
            hist_model[i] = '0;
            kern_model[i] = '0;
        end
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[k]) begin
            w = '{dir_rows[k].req, dir_rows[k].idx, dir_rows[k].coef,
                  dir_rows[k].smp, dir_rows[k].start};
            send_word(w, dir_rows[k].pinned, dir_rows[k].want);
        end

        // random episodes: mostly a few loads followed by one series
        while (sent_words < N_WORDS) begin
            src_calm = ($urandom_range(0, 3) == 0);
            kind     = $urandom_range(0, 11);
            if (kind == 0) begin
                // full-scale kernel and full-scale samples: largest sums
                ext = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
                for (int i = 0; i < NTAPS; i++) begin
                    w = '{REQ_LOAD, 5'(i), ext, 16'($urandom), 1'($urandom)};
                    send_word(w, 1'b0, '0);
                end
                len = $urandom_range(NTAPS, NTAPS + 6);
                for (int i = 0; i < len; i++) begin
                    w = '{REQ_SAMPLE, 5'($urandom), 16'($urandom),
                          ($urandom_range(0, 3) == 0) ? ~ext : ext, (i == 0)};
                    send_word(w, 1'b0, '0);
                end
            end else if (kind <= 8) begin
                nload = $urandom_range(0, 6);
                for (int i = 0; i < nload; i++) begin
                    w = '{REQ_LOAD, 5'($urandom), pick16(), 16'($urandom), 1'($urandom)};
                    send_word(w, 1'b0, '0);
                end
                len = $urandom_range(1, 45);
                for (int i = 0; i < len; i++) begin
                    // now and then retune a tap inside the series
                    if ($urandom_range(0, 11) == 0) begin
                        w = '{REQ_LOAD, 5'($urandom), pick16(), 16'($urandom), 1'($urandom)};
                        send_word(w, 1'b0, '0);
                    end
                    w = '{REQ_SAMPLE, 5'($urandom), 16'($urandom), pick16(),
                          (i == 0) || ($urandom_range(0, 39) == 0)};
                    send_word(w, 1'b0, '0);
                end
            end else begin
                // noise: any mix of kinds and flags
                len = $urandom_range(1, 8);
                for (int i = 0; i < len; i++) begin
                    w = '{1'($urandom), 5'($urandom), 16'($urandom), 16'($urandom),
                          1'($urandom)};
                    send_word(w, 1'b0, '0);
                end
            end
        end
        s_axis_tvalid <= 1'b0;

        // drain, then watch a little longer for stray result words
        while (conv_expected.size() != 0) @(posedge aclk);
        repeat (NTAPS + 16) @(posedge aclk);
        if (n_bad == 0 && conv_expected.size() == 0) begin
            $display("causal_fir_convolver test passed");
        end else begin
            $display("causal_fir_convolver test failed");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: random stalls, compare against the oldest expectation
    // ------------------------------------------------------------------
    initial begin
        conv_result_t want_r;
        int           stall;
        bit           sink_calm;
        n_bad         = 0;
        sink_calm     = 1'b0;
        m_axis_tready <= 1'b0;
        do @(posedge aclk); while (aresetn !== 1'b1);
        forever begin
            if ($urandom_range(0, 15) == 0) sink_calm = !sink_calm;
            stall = sink_calm ? 0 : $urandom_range(0, 7);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            @(posedge aclk);
            while (!m_axis_tvalid) @(posedge aclk);
            // result word taken at this edge
            if (conv_expected.size() == 0) begin
                n_bad++;
                if (n_bad <= 10)
                    $display("unexpected result word: conv_value=%0d saturated=%0b",
                             $signed(m_axis_tdata), m_axis_tuser[0]);
            end else begin
                want_r = conv_expected.pop_front();
                if (m_axis_tdata !== want_r.value || m_axis_tuser[0] !== want_r.sat) begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("mismatch: conv_value exp %0d got %0d, saturated exp %0b got %0b",
                                 want_r.value, $signed(m_axis_tdata), want_r.sat,
                                 m_axis_tuser[0]);
                end
            end
        end
    end

endmodule
